FILE: hw/rtl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg: shared definitions for the JSON pretty printer
// Character codes, the control word layout, the sequencer/datapath
// interface structs and the microcode program itself.
// ----------------------------------------------------------------------------
package jpp_pkg;

	// Formatting limits.
	localparam int MAX_DEPTH    = 7;
	localparam int INDENT_WIDTH = 4;

	// Signed nesting depth and the width of a space count for one indent.
	localparam int DEPTH_W = 4;
	localparam int SPC_W   = $clog2(MAX_DEPTH * INDENT_WIDTH + 1);

	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -DEPTH_MAX;

	// Characters the formatter reacts to or produces.
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Microcode store size and program counter width.
	localparam int UCODE_DEPTH = 24;
	localparam int PC_W        = $clog2(UCODE_DEPTH);

	// What a step puts out.
	typedef enum logic [2:0] {
		EM_NONE,
		EM_CH,
		EM_NL,
		EM_SP,
		EM_IND
	} emit_t;

	// What a step does to the nesting depth.
	typedef enum logic [1:0] {
		DP_KEEP,
		DP_UP,
		DP_DOWN
	} dep_t;

	// Jump condition of a step; C_NEXT never jumps, C_CLASS jumps by byte class.
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOPEND,
		C_CLOSER,
		C_CLASS,
		C_PLAIN_CLOSE,
		C_PREV_OPENER,
		C_MISMATCH,
		C_IN_STR,
		C_NOT_LAST,
		C_LAST
	} cond_t;

	// One control word.
	typedef struct packed {
		emit_t           emit;
		dep_t            dep;
		logic            clr_pend;
		logic            set_pend;
		logic            toggle;
		logic            finish;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic            busy;
		logic            go;
		logic            accept;
		logic [PC_W-1:0] pc;
		uword_t          uw;
	} ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic            pend;
		logic            closer;
		logic            in_str;
		logic            plain_close;
		logic            prev_opener;
		logic            mismatch;
		logic            last;
		logic [PC_W-1:0] class_pc;
		logic            done;
	} stat_t;

	// Microcode addresses.
	localparam logic [PC_W-1:0] P_PEND       = PC_W'(0);
	localparam logic [PC_W-1:0] P_PEND_UP    = PC_W'(1);
	localparam logic [PC_W-1:0] P_PEND_IND   = PC_W'(2);
	localparam logic [PC_W-1:0] P_MAIN       = PC_W'(3);
	localparam logic [PC_W-1:0] P_OPN        = PC_W'(4);
	localparam logic [PC_W-1:0] P_OPN_NL     = PC_W'(5);
	localparam logic [PC_W-1:0] P_CLS        = PC_W'(6);
	localparam logic [PC_W-1:0] P_CLS_CHK    = PC_W'(7);
	localparam logic [PC_W-1:0] P_CLS_NL     = PC_W'(8);
	localparam logic [PC_W-1:0] P_CLS_IND    = PC_W'(9);
	localparam logic [PC_W-1:0] P_CLS_MT     = PC_W'(10);
	localparam logic [PC_W-1:0] P_CLS_MT_IND = PC_W'(11);
	localparam logic [PC_W-1:0] P_CLS_CH     = PC_W'(12);
	localparam logic [PC_W-1:0] P_CMA        = PC_W'(13);
	localparam logic [PC_W-1:0] P_CMA_NL     = PC_W'(14);
	localparam logic [PC_W-1:0] P_CMA_IND    = PC_W'(15);
	localparam logic [PC_W-1:0] P_CLN        = PC_W'(16);
	localparam logic [PC_W-1:0] P_CLN_SP     = PC_W'(17);
	localparam logic [PC_W-1:0] P_TAIL       = PC_W'(18);
	localparam logic [PC_W-1:0] P_TAILP      = PC_W'(19);
	localparam logic [PC_W-1:0] P_TAIL_UP    = PC_W'(20);
	localparam logic [PC_W-1:0] P_TAIL_IND   = PC_W'(21);
	localparam logic [PC_W-1:0] P_OTH        = PC_W'(22);
	localparam logic [PC_W-1:0] P_FIN        = PC_W'(23);

	function automatic logic is_opener(logic [7:0] c);
		return (c == CH_LBRACE) || (c == CH_LBRACK);
	endfunction

	function automatic logic is_closer(logic [7:0] c);
		return (c == CH_RBRACE) || (c == CH_RBRACK);
	endfunction

	function automatic uword_t uw_make(emit_t e, dep_t d, logic clr, logic set,
			logic tog, logic fin, cond_t c, logic [PC_W-1:0] t);
		uword_t w;
		w.emit     = e;
		w.dep      = d;
		w.clr_pend = clr;
		w.set_pend = set;
		w.toggle   = tog;
		w.finish   = fin;
		w.cond     = c;
		w.target   = t;
		return w;
	endfunction

	// The program. Each item starts at P_PEND when an indent is pending,
	// otherwise at P_MAIN, and always leaves through P_FIN.
	function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			// Settle a pending indent unless this byte closes a bracket.
			P_PEND:       w = uw_make(EM_NONE, DP_KEEP, 1'b1, 1'b0, 1'b0, 1'b0,
			                          C_CLOSER, P_MAIN);
			P_PEND_UP:    w = uw_make(EM_NONE, DP_UP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_MAIN);
			P_PEND_IND:   w = uw_make(EM_IND, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_MAIN);
			// Dispatch on the class of the byte.
			P_MAIN:       w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_CLASS, P_OTH);
			// Opening bracket.
			P_OPN:        w = uw_make(EM_CH, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_IN_STR, P_TAIL);
			P_OPN_NL:     w = uw_make(EM_NL, DP_KEEP, 1'b0, 1'b1, 1'b0, 1'b0,
			                          C_ALWAYS, P_TAIL);
			// Closing bracket.
			P_CLS:        w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_PLAIN_CLOSE, P_CLS_CH);
			P_CLS_CHK:    w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_PREV_OPENER, P_CLS_MT);
			P_CLS_NL:     w = uw_make(EM_NL, DP_DOWN, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_CLS_CH);
			P_CLS_IND:    w = uw_make(EM_IND, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_ALWAYS, P_CLS_CH);
			P_CLS_MT:     w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_MISMATCH, P_CLS_CH);
			P_CLS_MT_IND: w = uw_make(EM_IND, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_CLS_CH);
			P_CLS_CH:     w = uw_make(EM_CH, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_ALWAYS, P_TAIL);
			// Comma.
			P_CMA:        w = uw_make(EM_CH, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_IN_STR, P_TAIL);
			P_CMA_NL:     w = uw_make(EM_NL, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_TAIL);
			P_CMA_IND:    w = uw_make(EM_IND, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_ALWAYS, P_TAIL);
			// Colon.
			P_CLN:        w = uw_make(EM_CH, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_IN_STR, P_TAIL);
			P_CLN_SP:     w = uw_make(EM_SP, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_TAIL);
			// End of the item: settle an open indent at the end of the text.
			P_TAIL:       w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NOT_LAST, P_FIN);
			P_TAILP:      w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NOPEND, P_FIN);
			P_TAIL_UP:    w = uw_make(EM_NONE, DP_UP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_NEXT, P_FIN);
			P_TAIL_IND:   w = uw_make(EM_IND, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b0,
			                          C_ALWAYS, P_FIN);
			// Any other byte, quotes included; falls into the finish step unless it ends the text.
			P_OTH:        w = uw_make(EM_CH, DP_KEEP, 1'b0, 1'b0, 1'b1, 1'b0,
			                          C_LAST, P_TAILP);
			P_FIN:        w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b1,
			                          C_NEXT, P_FIN);
			default:      w = uw_make(EM_NONE, DP_KEEP, 1'b0, 1'b0, 1'b0, 1'b1,
			                          C_NEXT, P_FIN);
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/jpp_seq.sv
// ----------------------------------------------------------------------------
// jpp_seq: microcode sequencer
// Holds the step counter, reads the control word for the current step and
// chooses the next step from the jump condition and the datapath status.
// ----------------------------------------------------------------------------
module jpp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jpp_pkg::stat_t  stat,
	output jpp_pkg::ctrl_t  ctrl
);

	logic                       busy_q;
	logic [jpp_pkg::PC_W-1:0]   pc_q;
	logic [jpp_pkg::PC_W-1:0]   pc_next;
	logic                       taken;
	logic                       accept;
	logic                       go;
	jpp_pkg::uword_t            uw;

	// Control word of the current step.
	assign uw     = jpp_pkg::ucode_rom(pc_q);
	assign accept = in_valid && !busy_q;
	assign go     = busy_q && stat.done;
	assign in_ready = !busy_q;

	// Evaluate the jump condition.
	always_comb begin
		case (uw.cond)
			jpp_pkg::C_NEXT:        taken = 1'b0;
			jpp_pkg::C_ALWAYS:      taken = 1'b1;
			jpp_pkg::C_NOPEND:      taken = !stat.pend;
			jpp_pkg::C_CLOSER:      taken = stat.closer;
			jpp_pkg::C_CLASS:       taken = 1'b1;
			jpp_pkg::C_PLAIN_CLOSE: taken = stat.plain_close;
			jpp_pkg::C_PREV_OPENER: taken = stat.prev_opener;
			jpp_pkg::C_MISMATCH:    taken = stat.mismatch;
			jpp_pkg::C_IN_STR:      taken = stat.in_str;
			jpp_pkg::C_NOT_LAST:    taken = !stat.last;
			jpp_pkg::C_LAST:        taken = stat.last;
			default:                taken = 1'b0;
		endcase
		if (!taken) begin
			pc_next = jpp_pkg::PC_W'(pc_q + 1'b1);
		end else if (uw.cond == jpp_pkg::C_CLASS) begin
			pc_next = stat.class_pc;
		end else begin
			pc_next = uw.target;
		end
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= jpp_pkg::P_MAIN;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= stat.pend ? jpp_pkg::P_PEND : jpp_pkg::P_MAIN;
		end else if (go) begin
			if (uw.finish) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_next;
			end
		end
	end

	assign ctrl.busy   = busy_q;
	assign ctrl.go     = go;
	assign ctrl.accept = accept;
	assign ctrl.pc     = pc_q;
	assign ctrl.uw     = uw;

endmodule

FILE: hw/rtl/jpp_dp.sv
// ----------------------------------------------------------------------------
// jpp_dp: formatter datapath
// Holds the text state, the current byte, the indent space counter, a
// one-character staging register and the output register.
// ----------------------------------------------------------------------------
module jpp_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  jpp_pkg::ctrl_t  ctrl,
	input  logic [7:0]      in_byte,
	input  logic            end_of_text,
	output jpp_pkg::stat_t  stat,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            run_end
);

	logic [7:0]                         ch_q;
	logic                               last_q;
	logic                               in_str_q;
	logic [7:0]                         prev_q;
	logic                               seen_q;
	logic signed [jpp_pkg::DEPTH_W-1:0] depth_q;
	logic                               pend_q;
	logic                               sp_busy_q;
	logic [jpp_pkg::SPC_W-1:0]          sp_cnt_q;
	logic                               st_valid_q;
	logic [7:0]                         st_byte_q;
	logic                               m_valid_q;
	logic [7:0]                         m_byte_q;
	logic                               m_last_q;

	logic                               out_free;
	logic                               can_emit;
	logic                               emit_v;
	logic                               emit_fire;
	logic                               done;
	logic [7:0]                         ebyte;
	logic [jpp_pkg::DEPTH_W-2:0]        depth_mag;
	logic [jpp_pkg::SPC_W-1:0]          spc_total;
	logic                               push;
	logic                               fin_go;
	logic                               escaped;
	logic [jpp_pkg::PC_W-1:0]           class_pc;

	// Spaces for the current depth; zero or negative depth gives none.
	assign depth_mag = (depth_q > 0) ? depth_q[jpp_pkg::DEPTH_W-2:0] : '0;
	assign spc_total = jpp_pkg::SPC_W'(depth_mag) * jpp_pkg::SPC_W'(jpp_pkg::INDENT_WIDTH);

	// A character may be produced when the staging slot is empty or can move on.
	assign out_free = !m_valid_q || out_ready;
	assign can_emit = !st_valid_q || out_free;

	// Per-step emission and completion.
	always_comb begin
		emit_v = 1'b0;
		done   = 1'b1;
		ebyte  = ch_q;
		case (ctrl.uw.emit)
			jpp_pkg::EM_NONE: begin
				done = ctrl.uw.finish ? out_free : 1'b1;
			end
			jpp_pkg::EM_CH: begin
				emit_v = 1'b1;
				done   = can_emit;
			end
			jpp_pkg::EM_NL: begin
				emit_v = 1'b1;
				done   = can_emit;
				ebyte  = jpp_pkg::CH_NL;
			end
			jpp_pkg::EM_SP: begin
				emit_v = 1'b1;
				done   = can_emit;
				ebyte  = jpp_pkg::CH_SPACE;
			end
			jpp_pkg::EM_IND: begin
				ebyte = jpp_pkg::CH_SPACE;
				if (sp_busy_q) begin
					emit_v = 1'b1;
					done   = can_emit && (sp_cnt_q == jpp_pkg::SPC_W'(1));
				end else if (spc_total == '0) begin
					done = 1'b1;
				end else begin
					emit_v = 1'b1;
					done   = can_emit && (spc_total == jpp_pkg::SPC_W'(1));
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign emit_fire = ctrl.busy && emit_v && can_emit;
	assign fin_go    = ctrl.go && ctrl.uw.finish;
	assign push      = (emit_fire && st_valid_q) || fin_go;
	assign escaped   = seen_q && (prev_q == jpp_pkg::CH_BSLASH);

	// Branch target for the byte class.
	always_comb begin
		if (jpp_pkg::is_opener(ch_q)) begin
			class_pc = jpp_pkg::P_OPN;
		end else if (jpp_pkg::is_closer(ch_q)) begin
			class_pc = jpp_pkg::P_CLS;
		end else if (ch_q == jpp_pkg::CH_COMMA) begin
			class_pc = jpp_pkg::P_CMA;
		end else if (ch_q == jpp_pkg::CH_COLON) begin
			class_pc = jpp_pkg::P_CLN;
		end else begin
			class_pc = jpp_pkg::P_OTH;
		end
	end

	// Text state, indent counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q   <= 1'b0;
			prev_q     <= '0;
			seen_q     <= 1'b0;
			depth_q    <= '0;
			pend_q     <= 1'b0;
			sp_busy_q  <= 1'b0;
			sp_cnt_q   <= '0;
			st_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			// Space counter of an indent step.
			if (emit_fire && (ctrl.uw.emit == jpp_pkg::EM_IND)) begin
				if (!sp_busy_q) begin
					if (spc_total != jpp_pkg::SPC_W'(1)) begin
						sp_busy_q <= 1'b1;
						sp_cnt_q  <= spc_total - 1'b1;
					end
				end else if (sp_cnt_q == jpp_pkg::SPC_W'(1)) begin
					sp_busy_q <= 1'b0;
				end else begin
					sp_cnt_q <= sp_cnt_q - 1'b1;
				end
			end

			// Staging slot and output register.
			if (fin_go) begin
				st_valid_q <= 1'b0;
			end else if (emit_fire) begin
				st_valid_q <= 1'b1;
			end
			if (push) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end

			// Actions of a completed step.
			if (ctrl.go) begin
				if (ctrl.uw.clr_pend) begin
					pend_q <= 1'b0;
				end
				if (ctrl.uw.set_pend) begin
					pend_q <= 1'b1;
				end
				case (ctrl.uw.dep)
					jpp_pkg::DP_UP: begin
						if (depth_q < jpp_pkg::DEPTH_MAX) begin
							depth_q <= depth_q + jpp_pkg::DEPTH_W'(1);
						end
					end
					jpp_pkg::DP_DOWN: begin
						if (depth_q > jpp_pkg::DEPTH_MIN) begin
							depth_q <= depth_q - jpp_pkg::DEPTH_W'(1);
						end
					end
					default: begin
					end
				endcase
				if (ctrl.uw.toggle && (ch_q == jpp_pkg::CH_QUOTE) && !escaped) begin
					in_str_q <= !in_str_q;
				end
				// The end of the text returns the text state and depth to the reset state.
				if (ctrl.uw.finish) begin
					if (last_q) begin
						in_str_q <= 1'b0;
						prev_q   <= '0;
						seen_q   <= 1'b0;
						depth_q  <= '0;
						pend_q   <= 1'b0;
					end else begin
						prev_q <= ch_q;
						seen_q <= 1'b1;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			ch_q   <= in_byte;
			last_q <= end_of_text;
		end
		if (emit_fire) begin
			st_byte_q <= ebyte;
		end
		if (push) begin
			m_byte_q <= st_byte_q;
			m_last_q <= fin_go;
		end
	end

	assign stat.pend        = pend_q;
	assign stat.closer      = jpp_pkg::is_closer(ch_q);
	assign stat.in_str      = in_str_q;
	assign stat.plain_close = in_str_q || !seen_q;
	assign stat.prev_opener = jpp_pkg::is_opener(prev_q);
	assign stat.mismatch    = !(((prev_q == jpp_pkg::CH_LBRACK) && (ch_q == jpp_pkg::CH_RBRACK))
	                         || ((prev_q == jpp_pkg::CH_LBRACE) && (ch_q == jpp_pkg::CH_RBRACE)));
	assign stat.last        = last_q;
	assign stat.class_pc    = class_pc;
	assign stat.done        = done;

	assign out_valid = m_valid_q;
	assign out_byte  = m_byte_q;
	assign run_end   = m_last_q;

endmodule

FILE: hw/rtl/json_pretty_printer.sv
// ----------------------------------------------------------------------------
// json_pretty_printer: streaming JSON reformatter
// Takes JSON text one byte per transaction and emits the indented text one
// character per transaction.
//
// Usage:
//   Input channel s_axis: tdata carries one character, tlast marks the last
//   character of a text; all formatting state returns to its reset value
//   after that character. Output channel m_axis: tdata carries one output
//   character, tlast marks the last character caused by one input character.
//   One input byte gives 1 to 58 output characters.
//   Timing: the microcode sequencer handles one input byte at a time. An
//   ordinary character passes through the accept, dispatch, emit and
//   finish steps. Each further output character and each control step of
//   the program (bracket checks, depth changes, end-of-text checks, an
//   indent of zero spaces) adds to the work on that byte. The last
//   character of an input byte is held in a staging register until the
//   sequencer knows it ends the run, and only then moves to m_axis.
//   Reset clears the nesting depth, string state and pending indent; the
//   block is ready from the first clock edge after reset is released. A
//   stall on m_axis holds the output register and, through it, the sequencer.
// ----------------------------------------------------------------------------
module json_pretty_printer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	jpp_pkg::ctrl_t ctrl;
	jpp_pkg::stat_t stat;

	// Step counter and microcode store.
	jpp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Text state and character output.
	jpp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_byte     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.run_end     (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// An accepted byte keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a byte is still in work");

	// The step counter stays inside the program while busy.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.busy |-> (ctrl.pc <= jpp_pkg::P_FIN))
		else $error("step counter left the microcode program");

	// The finish step returns the block to ready and puts out the last character of the run.
	a_ready_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.go && ctrl.uw.finish) |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
		else $error("finish step did not release the input or close the run");
`endif

endmodule
